>>> rtl/prdg_pkg.sv
// ----------------------------------------------------------------------------
// prdg_pkg
// Shared constants, register indexes and types of the primary ray generator.
// ----------------------------------------------------------------------------
`default_nettype none

package prdg_pkg;

  // Field widths
  localparam int PIX_W      = 12;
  localparam int DIM_W      = 13;
  localparam int IDX_W      = 24;
  localparam int DIR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Number formats
  localparam int MAX_DIM    = 4096;
  localparam int COEFF_W    = 16;
  localparam int COEFF_FRAC = COEFF_W - 5;
  localparam int DIR_FRAC   = 14;
  localparam int NDC_FRAC   = 16;
  localparam int NDCN_W     = PIX_W + NDC_FRAC + 2;
  localparam int NDC_W      = NDC_FRAC + 2;
  localparam int PROD_W     = COEFF_W + NDC_W;
  localparam int T_W        = PROD_W + 2;
  localparam int NORM_W     = 30;
  localparam int SQ_W       = 2 * NORM_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int RPROD_W    = 2 * COEFF_W;
  localparam int ACC_W      = RPROD_W + 2;
  localparam int RND_W      = ACC_W - COEFF_FRAC;

  // Restoring divider, used by the NDC mapping and the normalization
  localparam int DIV_NUM_W  = NORM_W + DIR_FRAC + 1;
  localparam int DIV_DEN_W  = SUM_W / 2;
  localparam int DIV_Q_W    = NDC_FRAC + 1;

  // Integer square root
  localparam int SQ_STAGES  = SUM_W / 2;
  localparam int SQ_OUT_W   = SUM_W / 2;

  // Decoupling queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNP0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNP1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNP2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROT0   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROT1   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROT2   = 3'd7;

  localparam int N_UNP = 12;
  localparam int N_ROT = 9;

  typedef struct packed {
    logic [N_UNP-1:0][COEFF_W-1:0] unproj;
    logic [N_ROT-1:0][COEFF_W-1:0] rot;
  } coeff_t;

  // One classified pixel word on its way from front to back
  typedef struct packed {
    logic [IDX_W-1:0]  pixel_index;
    logic              degen;
    logic [NDCN_W-1:0] num_x;
    logic [NDCN_W-1:0] num_y;
    logic [DIM_W-1:0]  den_x;
    logic [DIM_W-1:0]  den_y;
  } qword_t;

endpackage

`default_nettype wire

>>> rtl/prdg_pixel_if.sv
// ----------------------------------------------------------------------------
// prdg_pixel_if
// Pixel coordinate channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface prdg_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [prdg_pkg::PIX_W-1:0]    pixel_x;
  logic [prdg_pkg::PIX_W-1:0]    pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

`default_nettype wire

>>> rtl/prdg_ray_if.sv
// ----------------------------------------------------------------------------
// prdg_ray_if
// Ray direction result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface prdg_ray_if;
  logic                              valid;
  logic                              ready;
  logic [prdg_pkg::IDX_W-1:0]        pixel_index;
  logic signed [prdg_pkg::DIR_W-1:0] dir_x;
  logic signed [prdg_pkg::DIR_W-1:0] dir_y;
  logic signed [prdg_pkg::DIR_W-1:0] dir_z;
  logic                              degenerate;

  modport source (output valid, pixel_index, dir_x, dir_y, dir_z, degenerate, input ready);
  modport sink (input valid, pixel_index, dir_x, dir_y, dir_z, degenerate, output ready);
endinterface

`default_nettype wire

>>> rtl/prdg_cfg_if.sv
// ----------------------------------------------------------------------------
// prdg_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface prdg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [prdg_pkg::CFG_IDX_W-1:0]    index;
  logic [prdg_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/prdg_div.sv
// ----------------------------------------------------------------------------
// prdg_div
// Pipelined restoring divider, one quotient bit per stage, enable-stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module prdg_div (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [prdg_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [prdg_pkg::DIV_DEN_W-1:0] den,
  output logic      [prdg_pkg::DIV_Q_W-1:0]   quo
);
  import prdg_pkg::*;

  localparam int CMP_W = DIV_DEN_W + DIV_Q_W;

  logic [DIV_NUM_W-1:0] rem [DIV_Q_W];
  logic [DIV_DEN_W-1:0] dq  [DIV_Q_W];
  logic [DIV_Q_W-1:0]   qq  [DIV_Q_W];

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_stage
    logic [DIV_NUM_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_Q_W-1:0]   q_in;
    logic [CMP_W-1:0]     sh;
    logic [CMP_W-1:0]     re;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign den_in = dq[k-1];
      assign q_in   = qq[k-1];
    end

    assign sh = CMP_W'(den_in) << (DIV_Q_W - 1 - k);
    assign re = CMP_W'(rem_in);
    assign ge = (re >= sh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? DIV_NUM_W'(re - sh) : rem_in;
        dq[k]  <= den_in;
        qq[k]  <= {q_in[DIV_Q_W-2:0], ge};
      end
    end
  end

  assign quo = qq[DIV_Q_W-1];

endmodule

`default_nettype wire

>>> rtl/prdg_isqrt.sv
// ----------------------------------------------------------------------------
// prdg_isqrt
// Pipelined integer square root, one result bit per stage, enable-stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module prdg_isqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [prdg_pkg::SUM_W-1:0]    val,
  output logic      [prdg_pkg::SQ_OUT_W-1:0] root
);
  import prdg_pkg::*;

  logic [SUM_W-1:0] rv [SQ_STAGES];
  logic [SUM_W-1:0] rr [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    localparam logic [SUM_W:0] BIT = (SUM_W + 1)'(1) << (2 * (SQ_STAGES - 1 - k));
    logic [SUM_W-1:0] v_in;
    logic [SUM_W-1:0] r_in;
    logic [SUM_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in = val;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = rv[k-1];
      assign r_in = rr[k-1];
    end

    assign trial = (SUM_W + 1)'(r_in) + BIT;
    assign ge    = ((SUM_W + 1)'(v_in) >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rv[k] <= ge ? SUM_W'((SUM_W + 1)'(v_in) - trial) : v_in;
        rr[k] <= ge ? SUM_W'((SUM_W + 1)'(r_in >> 1) + BIT) : (r_in >> 1);
      end
    end
  end

  assign root = SQ_OUT_W'(rr[SQ_STAGES-1]);

endmodule

`default_nettype wire

>>> rtl/prdg_fifo.sv
// ----------------------------------------------------------------------------
// prdg_fifo
// Short queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none

module prdg_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire prdg_pkg::qword_t  din,
  output logic                   full,
  input  wire logic              pop,
  output prdg_pkg::qword_t       dout,
  output logic                   empty
);
  import prdg_pkg::*;

  qword_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (FIFO_PTR_W + 1)'(do_push) - (FIFO_PTR_W + 1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

>>> rtl/prdg_front.sv
// ----------------------------------------------------------------------------
// prdg_front
// Holds the configuration registers, accepts pixel words, checks them
// against the viewport and prepares the NDC division operands.
// ----------------------------------------------------------------------------
`default_nettype none

module prdg_front (
  input  wire logic         clk,
  input  wire logic         rst,
  prdg_pixel_if.sink        pix,
  prdg_cfg_if.sink          cfg,
  input  wire logic         full,
  output logic              push,
  output prdg_pkg::qword_t  word,
  output prdg_pkg::coeff_t  coeffs
);
  import prdg_pkg::*;

  logic [DIM_W-1:0]      width;
  logic [DIM_W-1:0]      height;
  logic [CFG_DATA_W-1:0] unp [3];
  logic [CFG_DATA_W-1:0] rot [2];
  logic [COEFF_W-1:0]    rot_last;
  logic [DIM_W-1:0]      w_eff;
  logic [DIM_W-1:0]      h_eff;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width    <= DIM_W'(1);
      height   <= DIM_W'(1);
      unp[0]   <= '0;
      unp[1]   <= '0;
      unp[2]   <= '0;
      rot[0]   <= '0;
      rot[1]   <= '0;
      rot_last <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WIDTH:  width    <= cfg.data[DIM_W-1:0];
        REG_HEIGHT: height   <= cfg.data[DIM_W-1:0];
        REG_UNP0:   unp[0]   <= cfg.data;
        REG_UNP1:   unp[1]   <= cfg.data;
        REG_UNP2:   unp[2]   <= cfg.data;
        REG_ROT0:   rot[0]   <= cfg.data;
        REG_ROT1:   rot[1]   <= cfg.data;
        REG_ROT2:   rot_last <= cfg.data[COEFF_W-1:0];
      endcase
    end
  end

  assign coeffs.unproj = {unp[2], unp[1], unp[0]};
  assign coeffs.rot    = {rot_last, rot[1], rot[0]};

  // clamp oversized viewport
  assign w_eff = (width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width;
  assign h_eff = (height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height;

  assign pix.ready = !full;
  assign push      = pix.valid && !full;

  always_comb begin
    word.pixel_index = IDX_W'(pix.pixel_x) + IDX_W'(pix.pixel_y) * IDX_W'(w_eff);
    word.degen       = (w_eff == '0) || (h_eff == '0) ||
                       (DIM_W'(pix.pixel_x) >= w_eff) || (DIM_W'(pix.pixel_y) >= h_eff);
    word.num_x       = NDCN_W'({pix.pixel_x, {(NDC_FRAC + 1){1'b0}}}) + NDCN_W'(w_eff >> 1);
    word.num_y       = NDCN_W'({pix.pixel_y, {(NDC_FRAC + 1){1'b0}}}) + NDCN_W'(h_eff >> 1);
    word.den_x       = w_eff;
    word.den_y       = h_eff;
  end

endmodule

`default_nettype wire

>>> rtl/prdg_back.sv
// ----------------------------------------------------------------------------
// prdg_back
// Arithmetic pipeline: NDC division, unprojection, normalization, rotation,
// rounding and the output register. One enable stalls every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module prdg_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire prdg_pkg::qword_t  qd,
  input  wire logic              empty,
  output logic                   pop,
  input  wire prdg_pkg::coeff_t  coeffs,
  prdg_ray_if.source             ray
);
  import prdg_pkg::*;

  typedef struct packed {
    logic             degen;
    logic [IDX_W-1:0] idx;
  } sb1_t;

  typedef struct packed {
    logic                         degen;
    logic [IDX_W-1:0]             idx;
    logic [2:0][NORM_W-1:0]       v;
    logic [2:0]                   neg;
  } sb2_t;

  typedef struct packed {
    logic             degen;
    logic [IDX_W-1:0] idx;
    logic [2:0]       neg;
  } sb3_t;

  logic adv;
  logic o_valid;

  assign adv       = !o_valid || ray.ready;
  assign pop       = adv && !empty;
  assign ray.valid = o_valid;

  // ---- NDC division ----
  logic [DIV_Q_W-1:0] qx;
  logic [DIV_Q_W-1:0] qy;
  logic [DIV_Q_W-1:0] v1;
  sb1_t               sb1 [DIV_Q_W];

  prdg_div u_div_x (.clk, .en(adv), .num(DIV_NUM_W'(qd.num_x)),
                    .den(DIV_DEN_W'(qd.den_x)), .quo(qx));
  prdg_div u_div_y (.clk, .en(adv), .num(DIV_NUM_W'(qd.num_y)),
                    .den(DIV_DEN_W'(qd.den_y)), .quo(qy));

  // ---- unprojection products, sums, normalization, squares ----
  logic                     p_valid, t_valid, n_valid, s_valid, q_valid;
  sb1_t                     p_sb, t_sb;
  logic signed [PROD_W-1:0] prod [4][2];
  logic signed [T_W-1:0]    t [4];
  logic signed [NDC_W-1:0]  nx;
  logic signed [NDC_W-1:0]  ny;

  assign nx = $signed({1'b0, qx}) - NDC_W'(1 << NDC_FRAC);
  assign ny = $signed({1'b0, qy}) - NDC_W'(1 << NDC_FRAC);

  // normalize stage combinational part
  logic [T_W-1:0]          mag [3];
  logic [T_W-1:0]          mx;
  logic [2:0]              negv;
  logic [$clog2(T_W)-1:0]  sft;
  logic [2:0][NORM_W-1:0]  vnorm;

  always_comb begin
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i]  = t[i][T_W-1] ? T_W'(-t[i]) : T_W'(t[i]);
      negv[i] = t[i][T_W-1] ^ t[3][T_W-1];
      if (mag[i] > mx) mx = mag[i];
    end
    sft = '0;
    for (int k = 1; k <= T_W - NORM_W; k++) begin
      if ((mx >> (k - 1)) >= (T_W'(1) << NORM_W)) sft = ($clog2(T_W))'(k);
    end
    for (int i = 0; i < 3; i++) begin
      vnorm[i] = NORM_W'(mag[i] >> sft);
    end
  end

  sb2_t             n_sb, s_sb, q_sb;
  logic [SQ_W-1:0]  sq [3];
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      sb1[0] <= '{degen: qd.degen, idx: qd.pixel_index};
      for (int k = 1; k < DIV_Q_W; k++) sb1[k] <= sb1[k-1];

      p_sb <= sb1[DIV_Q_W-1];
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= $signed(coeffs.unproj[3*r]) * nx;
        prod[r][1] <= $signed(coeffs.unproj[3*r+1]) * ny;
      end

      t_sb <= p_sb;
      for (int r = 0; r < 4; r++) begin
        t[r] <= T_W'(prod[r][0]) + T_W'(prod[r][1]) +
                (T_W'($signed(coeffs.unproj[3*r+2])) <<< NDC_FRAC);
      end

      n_sb.degen <= t_sb.degen || (t[3] == '0);
      n_sb.idx   <= t_sb.idx;
      n_sb.v     <= vnorm;
      n_sb.neg   <= negv;

      s_sb <= n_sb;
      for (int i = 0; i < 3; i++) sq[i] <= SQ_W'(n_sb.v[i]) * SQ_W'(n_sb.v[i]);

      q_sb <= s_sb;
      sum  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    end
  end

  // ---- square root ----
  logic [SQ_OUT_W-1:0] len;
  logic [SQ_STAGES-1:0] v2;
  sb2_t                 sb2 [SQ_STAGES];
  sb2_t                 sb2_end;

  prdg_isqrt u_isqrt (.clk, .en(adv), .val(sum), .root(len));

  assign sb2_end = sb2[SQ_STAGES-1];

  // ---- normalizing division ----
  logic [DIV_Q_W-1:0] qn [3];
  logic [DIV_Q_W-1:0] v3;
  sb3_t               sb3 [DIV_Q_W];
  sb3_t               sb3_end;

  for (genvar i = 0; i < 3; i++) begin : g_norm
    prdg_div u_div_n (
      .clk, .en(adv),
      .num(DIV_NUM_W'({sb2_end.v[i], {DIR_FRAC{1'b0}}}) + DIV_NUM_W'(len >> 1)),
      .den(DIV_DEN_W'(len)),
      .quo(qn[i])
    );
  end

  assign sb3_end = sb3[DIV_Q_W-1];

  // ---- rotation and output ----
  logic                      nn_valid, r_valid, a_valid;
  sb1_t                      nn_sb, r_sb, a_sb;
  logic signed [DIR_W-1:0]   nv [3];
  logic signed [RPROD_W-1:0] rp [3][3];
  logic signed [ACC_W-1:0]   acc [3];
  logic [ACC_W-1:0]          am [3];
  logic [RND_W-1:0]          qr [3];
  logic signed [DIR_W-1:0]   dir_c [3];
  logic [2:0]                sat;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      am[j] = acc[j][ACC_W-1] ? ACC_W'(-acc[j]) : ACC_W'(acc[j]);
      qr[j] = RND_W'((am[j] + (ACC_W'(1) << (COEFF_FRAC - 1))) >> COEFF_FRAC);
      if (acc[j][ACC_W-1]) begin
        sat[j]   = qr[j] > RND_W'(32768);
        dir_c[j] = sat[j] ? DIR_W'(-32768) : DIR_W'(-$signed({1'b0, qr[j]}));
      end else begin
        sat[j]   = qr[j] > RND_W'(32767);
        dir_c[j] = sat[j] ? DIR_W'(32767) : DIR_W'(qr[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb2[0] <= q_sb;
      for (int k = 1; k < SQ_STAGES; k++) sb2[k] <= sb2[k-1];

      sb3[0].degen <= sb2_end.degen || (len == '0);
      sb3[0].idx   <= sb2_end.idx;
      sb3[0].neg   <= sb2_end.neg;
      for (int k = 1; k < DIV_Q_W; k++) sb3[k] <= sb3[k-1];

      nn_sb <= '{degen: sb3_end.degen, idx: sb3_end.idx};
      for (int i = 0; i < 3; i++) begin
        nv[i] <= sb3_end.neg[i] ? -$signed(DIR_W'(qn[i])) : $signed(DIR_W'(qn[i]));
      end

      r_sb <= nn_sb;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          rp[j][k] <= $signed(coeffs.rot[3*j+k]) * nv[k];
        end
      end

      a_sb <= r_sb;
      for (int j = 0; j < 3; j++) begin
        acc[j] <= ACC_W'(rp[j][0]) + ACC_W'(rp[j][1]) + ACC_W'(rp[j][2]);
      end

      // words flagged degenerate upstream carry zero directions; saturation also flags a word degenerate
      ray.pixel_index <= a_sb.idx;
      ray.degenerate  <= a_sb.degen || (|sat);
      ray.dir_x       <= a_sb.degen ? '0 : dir_c[0];
      ray.dir_y       <= a_sb.degen ? '0 : dir_c[1];
      ray.dir_z       <= a_sb.degen ? '0 : dir_c[2];
    end
  end

  // valid bits of every stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= '0;
      p_valid  <= 1'b0;
      t_valid  <= 1'b0;
      n_valid  <= 1'b0;
      s_valid  <= 1'b0;
      q_valid  <= 1'b0;
      v2       <= '0;
      v3       <= '0;
      nn_valid <= 1'b0;
      r_valid  <= 1'b0;
      a_valid  <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      v1       <= {v1[DIV_Q_W-2:0], !empty};
      p_valid  <= v1[DIV_Q_W-1];
      t_valid  <= p_valid;
      n_valid  <= t_valid;
      s_valid  <= n_valid;
      q_valid  <= s_valid;
      v2       <= {v2[SQ_STAGES-2:0], q_valid};
      v3       <= {v3[DIV_Q_W-2:0], v2[SQ_STAGES-1]};
      nn_valid <= v3[DIV_Q_W-1];
      r_valid  <= nn_valid;
      a_valid  <= r_valid;
      o_valid  <= a_valid;
    end
  end

endmodule

`default_nettype wire

>>> rtl/primary_ray_direction_gen_top.sv
// ----------------------------------------------------------------------------
// primary_ray_direction_gen_top
// Pinhole camera primary ray generator: pixel in, unit world direction out.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock and returns one ray word per
// clock once the pipeline is full, while the ray side keeps ready high.
// An accepted pixel is written into the queue and leaves it when the
// back advances, straight into the first of 17 stages of NDC division,
// then unprojection and normalization set-up (products, sums, normalize,
// squares, sum of squares), the square root stages, the normalizing
// division stages, and rotation, rounding and the output register.
// Throughput is set by the pipelined dividers and square root, each of
// which retires one word per cycle unless stalled. The pixel side sees
// ready drop only when the four-word queue is full, which happens when
// the ray side holds ready low. Configuration writes are always
// accepted (ready is tied high) and take effect immediately; write them
// only while no pixel is in flight. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module primary_ray_direction_gen_top (
  input  wire logic  clk,
  input  wire logic  rst,
  prdg_pixel_if.sink pix,
  prdg_cfg_if.sink   cfg,
  prdg_ray_if.source ray
);
  import prdg_pkg::*;

  // front -> queue
  logic   push;
  logic   full;
  qword_t in_word;
  coeff_t coeffs;

  // queue -> back
  logic   pop;
  logic   empty;
  qword_t head;

  // classify and check each pixel against the viewport
  prdg_front u_front (
    .clk, .rst,
    .pix,
    .cfg,
    .full,
    .push,
    .word   (in_word),
    .coeffs
  );

  // decouple front from back so each stalls on its own
  prdg_fifo u_fifo (
    .clk, .rst,
    .push,
    .din   (in_word),
    .full,
    .pop,
    .dout  (head),
    .empty
  );

  // carry out the arithmetic and hold the result word
  prdg_back u_back (
    .clk, .rst,
    .qd     (head),
    .empty,
    .pop,
    .coeffs,
    .ray
  );

endmodule

`default_nettype wire
